// File: rtl/omni_pkg.sv
// Package with the widths, register indexes and frame constants of the omni wheel speed framer.
package omni_pkg;

    // Field widths.
    localparam int CMD_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int PROD_W     = CMD_W + GAIN_W + 1;
    localparam int WHEEL_W    = PROD_W + 3;
    localparam int MAG_W      = WHEEL_W - 1;
    localparam int LVL_W      = 8;
    localparam int NUM_W      = MAG_W + LVL_W;
    localparam int BYTE_W     = 8;
    localparam int NUM_WHEELS = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 3 * CMD_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_GAIN = 2'd2;

    // Gain reset values, unsigned Q4.12.
    localparam logic [GAIN_W-1:0] TURN_GAIN_RST    = 16'd21545;
    localparam logic [GAIN_W-1:0] LATERAL_GAIN_RST = 16'd410;
    localparam logic [GAIN_W-1:0] FORWARD_GAIN_RST = 16'd709;

    // Fixed frame bytes.
    localparam logic [BYTE_W-1:0] FRAME_SYNC0 = 8'hFF;
    localparam logic [BYTE_W-1:0] FRAME_SYNC1 = 8'hFE;
    localparam logic [BYTE_W-1:0] FRAME_ID    = 8'h02;
    localparam logic [BYTE_W-1:0] FRAME_PAD   = 8'h00;

    // Byte position within the ten-byte frame.
    typedef enum logic [3:0] {
        POS_SYNC0 = 4'd0,
        POS_SYNC1 = 4'd1,
        POS_ID    = 4'd2,
        POS_PAD_A = 4'd3,
        POS_LVL_A = 4'd4,
        POS_PAD_B = 4'd5,
        POS_LVL_B = 4'd6,
        POS_PAD_C = 4'd7,
        POS_LVL_C = 4'd8,
        POS_DIR   = 4'd9
    } t_frame_pos;

endpackage

// File: rtl/omni_wheel_speed_framer.sv
// Top level of the omni wheel speed framer: kinematics pipeline, level divider and byte framer.
//
// Usage: a motion command (forward, lateral, turn, signed Q8.8) enters on the s_axis channel,
// one transaction per command. For each command the block sends a ten-byte motor frame on the
// m_axis channel, one byte per transaction: FF FE 02 00 a 00 b 00 c dir, with tlast on the
// direction byte. a, b and c are wheel levels floor(|w| * SPEED_LEVELS / max|w|) over the
// three wheels; dir has 4, 2, 1 set when wheel A, B, C turns backward. All zero when every
// wheel speed is zero.
// The three Q4.12 gains are written through the cfg channel (index 0 turn, 1 lateral,
// 2 forward), which is always ready; writes to index 3 are dropped. Gains must change only
// while idle; the block does not enforce this. Pipeline: four stages of multiply, sum,
// magnitude and maximum, then eight restoring divider stages that each settle one level bit
// for all three wheels in parallel; the framer registers the result before its first byte.
// Throughput: the pipeline takes a command in every cycle unless frozen; the byte framer sends
// one byte per cycle while the receiver is ready, so frame length sets the sustained rate.
// Reset (synchronous, active low) restores the default gains and empties the pipeline and the
// framer. When the receiver stalls, the framer holds its byte and the whole pipeline freezes
// once its last stage is full; s_axis_tready then drops and nothing is lost or repeated.
module omni_wheel_speed_framer
    import omni_pkg::*;
#(
    parameter int SPEED_LEVELS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Command stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,  // forward_cmd, lateral_cmd, turn_cmd
    // Frame byte stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [BYTE_W-1:0]    m_axis_tdata,  // frame_byte
    output logic                 m_axis_tlast,  // frame_last
    // Gain register writes.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data
);

    localparam int DIV_STAGES = LVL_W;

    // Gain registers.
    logic [GAIN_W-1:0] r_turn_gain;
    logic [GAIN_W-1:0] r_lateral_gain;
    logic [GAIN_W-1:0] r_forward_gain;

    // Pipeline valid bits.
    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    logic [DIV_STAGES:0]   r_dv;

    // Stage 1: products.
    logic signed [PROD_W-1:0]  r_rt;
    logic signed [PROD_W-1:0]  r_lh;
    logic signed [PROD_W-1:0]  r_fv;
    // Stage 2: wheel speeds.
    logic signed [WHEEL_W-1:0] r_wheel [NUM_WHEELS];
    // Stage 3: magnitudes and direction.
    logic [MAG_W-1:0]          r_mag   [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]     r_dir3;
    // Divider stages: index 0 is loaded from the maximum stage.
    logic [NUM_W-1:0]          r_rem   [NUM_WHEELS][DIV_STAGES+1];
    logic [LVL_W-1:0]          r_quo   [NUM_WHEELS][DIV_STAGES+1];
    logic [MAG_W-1:0]          r_den   [DIV_STAGES+1];
    logic [NUM_WHEELS-1:0]     r_dir   [DIV_STAGES+1];

    // Byte framer.
    logic                  r_busy;
    t_frame_pos            r_pos;
    logic [LVL_W-1:0]      r_lvl [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] r_fdir;

    logic                  adv;
    logic                  ser_take;
    logic                  frame_done;

    logic signed [CMD_W-1:0]   cmd_fwd;
    logic signed [CMD_W-1:0]   cmd_lat;
    logic signed [CMD_W-1:0]   cmd_rot;
    logic signed [PROD_W-1:0]  n_rt;
    logic signed [PROD_W-1:0]  n_lh;
    logic signed [PROD_W-1:0]  n_fv;
    logic signed [WHEEL_W-1:0] n_wheel [NUM_WHEELS];
    logic [MAG_W-1:0]          n_mag   [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]     n_dir3;
    logic [MAG_W-1:0]          n_max;
    logic [MAG_W-1:0]          max_ab;
    logic [NUM_W-1:0]          n_num   [NUM_WHEELS];
    logic [NUM_W-1:0]          n_rem   [NUM_WHEELS][DIV_STAGES];
    logic [LVL_W-1:0]          n_quo   [NUM_WHEELS][DIV_STAGES];

    // The framer accepts a new result when empty or while sending its last byte.
    assign frame_done = r_busy && m_axis_tready && (r_pos == POS_DIR);
    assign ser_take   = !r_busy || frame_done;
    // The pipeline moves as a whole unless its last stage holds a result the framer cannot take.
    assign adv        = !r_dv[DIV_STAGES] || ser_take;

    assign s_axis_tready = adv;
    assign o_cfg_ready   = 1'b1;

    assign cmd_fwd = s_axis_tdata[CMD_W-1:0];
    assign cmd_lat = s_axis_tdata[2*CMD_W-1:CMD_W];
    assign cmd_rot = s_axis_tdata[3*CMD_W-1:2*CMD_W];

    // Stage 1: signed command times unsigned gain, exact in PROD_W bits.
    always_comb begin
        n_rt = cmd_rot * $signed({1'b0, r_turn_gain});
        n_lh = cmd_lat * $signed({1'b0, r_lateral_gain});
        n_fv = cmd_fwd * $signed({1'b0, r_forward_gain});
    end

    // Stage 2: wheel A, B and C speeds.
    always_comb begin
        n_wheel[0] = WHEEL_W'(r_rt) - (WHEEL_W'(r_lh) <<< 1);
        n_wheel[1] = WHEEL_W'(r_rt) + WHEEL_W'(r_lh) - WHEEL_W'(r_fv);
        n_wheel[2] = WHEEL_W'(r_rt) + WHEEL_W'(r_lh) + WHEEL_W'(r_fv);
    end

    // Stage 3: magnitudes; wheel A owns the top direction bit.
    always_comb begin
        for (int l = 0; l < NUM_WHEELS; l++) begin
            n_mag[l] = r_wheel[l][WHEEL_W-1] ? MAG_W'(-r_wheel[l]) : MAG_W'(r_wheel[l]);
            n_dir3[NUM_WHEELS-1-l] = r_wheel[l][WHEEL_W-1];
        end
    end

    // Stage 4: maximum over all three wheels and scaled numerators.
    always_comb begin
        max_ab = (r_mag[1] > r_mag[0]) ? r_mag[1] : r_mag[0];
        n_max  = (r_mag[2] > max_ab) ? r_mag[2] : max_ab;
        for (int l = 0; l < NUM_WHEELS; l++) begin
            n_num[l] = NUM_W'(r_mag[l]) * NUM_W'(SPEED_LEVELS);
        end
    end

    // Divider steps: stage s settles quotient bit LVL_W-1-s. A zero maximum yields level zero.
    always_comb begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            for (int l = 0; l < NUM_WHEELS; l++) begin
                if ((r_den[s] != '0) &&
                    (r_rem[l][s] >= (NUM_W'(r_den[s]) << (LVL_W - 1 - s)))) begin
                    n_rem[l][s] = r_rem[l][s] - (NUM_W'(r_den[s]) << (LVL_W - 1 - s));
                    n_quo[l][s] = {r_quo[l][s][LVL_W-2:0], 1'b1};
                end else begin
                    n_rem[l][s] = r_rem[l][s];
                    n_quo[l][s] = {r_quo[l][s][LVL_W-2:0], 1'b0};
                end
            end
        end
    end

    // Gain registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_gain    <= TURN_GAIN_RST;
            r_lateral_gain <= LATERAL_GAIN_RST;
            r_forward_gain <= FORWARD_GAIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TURN_GAIN:    r_turn_gain    <= i_cfg_data;
                CFG_LATERAL_GAIN: r_lateral_gain <= i_cfg_data;
                CFG_FORWARD_GAIN: r_forward_gain <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Valid bits travel with the data and freeze with it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_dv <= '0;
        end else if (adv) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_dv <= {r_dv[DIV_STAGES-1:0], r_v3};
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rt   <= n_rt;
            r_lh   <= n_lh;
            r_fv   <= n_fv;
            r_dir3 <= n_dir3;
            for (int l = 0; l < NUM_WHEELS; l++) begin
                r_wheel[l]    <= n_wheel[l];
                r_mag[l]      <= n_mag[l];
                r_rem[l][0]   <= n_num[l];
                r_quo[l][0]   <= '0;
            end
            r_den[0] <= n_max;
            r_dir[0] <= r_dir3;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_den[s+1] <= r_den[s];
                r_dir[s+1] <= r_dir[s];
                for (int l = 0; l < NUM_WHEELS; l++) begin
                    r_rem[l][s+1] <= n_rem[l][s];
                    r_quo[l][s+1] <= n_quo[l][s];
                end
            end
        end
    end

    // Byte framer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= POS_SYNC0;
        end else if (r_dv[DIV_STAGES] && ser_take) begin
            r_busy <= 1'b1;
            r_pos  <= POS_SYNC0;
        end else if (r_busy && m_axis_tready) begin
            if (r_pos == POS_DIR) begin
                r_busy <= 1'b0;
                r_pos  <= POS_SYNC0;
            end else begin
                r_pos  <= t_frame_pos'(r_pos + 4'd1);
            end
        end
    end

    // Byte framer payload, loaded with a finished result.
    always_ff @(posedge i_clk) begin
        if (r_dv[DIV_STAGES] && ser_take) begin
            r_fdir <= r_dir[DIV_STAGES];
            for (int l = 0; l < NUM_WHEELS; l++) begin
                r_lvl[l] <= r_quo[l][DIV_STAGES];
            end
        end
    end

    // Output byte selection.
    always_comb begin
        case (r_pos)
            POS_SYNC0: m_axis_tdata = FRAME_SYNC0;
            POS_SYNC1: m_axis_tdata = FRAME_SYNC1;
            POS_ID:    m_axis_tdata = FRAME_ID;
            POS_LVL_A: m_axis_tdata = r_lvl[0];
            POS_LVL_B: m_axis_tdata = r_lvl[1];
            POS_LVL_C: m_axis_tdata = r_lvl[2];
            POS_DIR:   m_axis_tdata = BYTE_W'(r_fdir);
            default:   m_axis_tdata = FRAME_PAD;
        endcase
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tlast  = (r_pos == POS_DIR);

endmodule

// File: dv/tb.sv
// Self-checking testbench for the omni wheel speed framer: command stream in, checked frame bytes out.
`timescale 1ns / 1ps

module tb;
    import omni_pkg::*;

    localparam int SPEED_LEVELS = 15;

    typedef logic signed [CMD_W-1:0] t_cmd;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [GAIN_W-1:0] t_gain;

    // One expected byte of the motor frame.
    typedef struct packed {
        t_byte data;
        logic  last;
    } t_frame_byte;

    // A directed command; the levels and direction are used only when typed is set.
    typedef struct packed {
        t_cmd  fwd;
        t_cmd  lat;
        t_cmd  turn;
        logic  typed;
        t_byte lvl_a;
        t_byte lvl_b;
        t_byte lvl_c;
        t_byte dir;
    } t_cmd_row;

    // Direction byte bits: set when the wheel turns backward.
    localparam t_byte DIR_NONE = 8'd0;
    localparam t_byte DIR_C    = 8'd1;
    localparam t_byte DIR_B    = 8'd2;
    localparam t_byte DIR_A    = 8'd4;

    localparam t_byte LVL_ZERO = 8'd0;
    localparam t_byte LVL_FULL = t_byte'(SPEED_LEVELS);
    localparam t_byte LVL_HALF = t_byte'(SPEED_LEVELS / 2);

    localparam t_cmd CMD_MAX  = 16'sh7FFF;
    localparam t_cmd CMD_MIN  = 16'sh8000;
    localparam t_cmd CMD_ZERO = 16'sh0000;
    localparam t_cmd CMD_NEG1 = 16'shFFFF;
    localparam t_cmd CMD_ONE  = 16'sh0001;

    localparam t_gain GAIN_MAX  = 16'hFFFF;
    localparam t_gain GAIN_ZERO = 16'h0000;

    // The package has no name for the unused register slot.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    localparam int IDLE_PCT      = 15;
    localparam int HOLD_AT_BYTE  = 350;
    localparam int HOLD_CYCLES   = 300;
    localparam int STEADY_FROM   = 900;
    localparam int STEADY_TO     = 1200;
    localparam int DRAIN_CYCLES  = 30;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int N_DIRECTED    = 20;

    // Directed commands under the reset gains. Rows with at most one nonzero field have
    // levels that follow from the wheel equations by inspection; the rest go to the predictor.
    localparam t_cmd_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{CMD_ZERO, CMD_ZERO, CMD_ZERO, 1'b1, LVL_ZERO, LVL_ZERO, LVL_ZERO, DIR_NONE},
        '{CMD_ZERO, CMD_ZERO, CMD_MAX,  1'b1, LVL_FULL, LVL_FULL, LVL_FULL, DIR_NONE},
        '{CMD_ZERO, CMD_ZERO, CMD_MIN,  1'b1, LVL_FULL, LVL_FULL, LVL_FULL,
          DIR_A | DIR_B | DIR_C},
        '{CMD_MAX,  CMD_ZERO, CMD_ZERO, 1'b1, LVL_ZERO, LVL_FULL, LVL_FULL, DIR_B},
        '{CMD_MIN,  CMD_ZERO, CMD_ZERO, 1'b1, LVL_ZERO, LVL_FULL, LVL_FULL, DIR_C},
        '{CMD_ZERO, CMD_MAX,  CMD_ZERO, 1'b1, LVL_FULL, LVL_HALF, LVL_HALF, DIR_A},
        '{CMD_ZERO, CMD_MIN,  CMD_ZERO, 1'b1, LVL_FULL, LVL_HALF, LVL_HALF, DIR_B | DIR_C},
        '{CMD_ONE,  CMD_ZERO, CMD_ZERO, 1'b1, LVL_ZERO, LVL_FULL, LVL_FULL, DIR_B},
        '{CMD_ZERO, CMD_ZERO, CMD_ONE,  1'b1, LVL_FULL, LVL_FULL, LVL_FULL, DIR_NONE},
        '{CMD_ZERO, CMD_ONE,  CMD_ZERO, 1'b1, LVL_FULL, LVL_HALF, LVL_HALF, DIR_A},
        '{CMD_NEG1, CMD_NEG1, CMD_NEG1, 1'b0, LVL_ZERO, LVL_ZERO, LVL_ZERO, DIR_NONE},
        '{CMD_MAX,  CMD_MAX,  CMD_MAX,  1'b0, LVL_ZERO, LVL_ZERO, LVL_ZERO, DIR_NONE},
        '{CMD_MIN,  CMD_MIN,  CMD_MIN,  1'b0, LVL_ZERO, LVL_ZERO, LVL_ZERO, DIR_NONE},
        '{CMD_MAX,  CMD_MIN,  CMD_MAX,  1'b0, LVL_ZERO, LVL_ZERO, LVL_ZERO, DIR_NONE},
        '{CMD_MIN,  CMD_MAX,  CMD_MIN,  1'b0, LVL_ZERO, LVL_ZERO, LVL_ZERO, DIR_NONE},
        '{16'sh0100, CMD_ZERO, 16'sh0100, 1'b0, LVL_ZERO, LVL_ZERO, LVL_ZERO, DIR_NONE},
        '{16'sh0100, CMD_ZERO, 16'shFF00, 1'b0, LVL_ZERO, LVL_ZERO, LVL_ZERO, DIR_NONE},
        '{16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, LVL_ZERO, LVL_ZERO, LVL_ZERO, DIR_NONE},
        '{16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, LVL_ZERO, LVL_ZERO, LVL_ZERO, DIR_NONE},
        '{16'sh1234, 16'sh0F0F, 16'shF0F0, 1'b0, LVL_ZERO, LVL_ZERO, LVL_ZERO, DIR_NONE}
    };

    // Clock, reset and every block input start at known values.
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [GAIN_W-1:0]    i_cfg_data    = '0;

    // Shadow copy of the gain registers, updated on each accepted write.
    t_gain gain_turn    = TURN_GAIN_RST;
    t_gain gain_lateral = LATERAL_GAIN_RST;
    t_gain gain_forward = FORWARD_GAIN_RST;

    // Frame bytes predicted for accepted commands, oldest first.
    t_frame_byte expected_bytes_q[$];

    int  mismatch_count = 0;
    int  bytes_seen     = 0;
    int  cycle_count    = 0;
    bit  sender_steady  = 1'b0;

    omni_wheel_speed_framer #(
        .SPEED_LEVELS(SPEED_LEVELS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // The run is bounded; a hang anywhere ends it as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("omni_wheel_speed_framer verification failed");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    task automatic push_byte(input t_byte data, input logic last);
        expected_bytes_q.push_back('{data: data, last: last});
    endtask

    // Queue one full frame: sync, id, then the three levels each behind a pad, then direction.
    task automatic push_frame(input t_byte lvl_a, lvl_b, lvl_c, dir);
        push_byte(FRAME_SYNC0, 1'b0);
        push_byte(FRAME_SYNC1, 1'b0);
        push_byte(FRAME_ID, 1'b0);
        push_byte(FRAME_PAD, 1'b0);
        push_byte(lvl_a, 1'b0);
        push_byte(FRAME_PAD, 1'b0);
        push_byte(lvl_b, 1'b0);
        push_byte(FRAME_PAD, 1'b0);
        push_byte(lvl_c, 1'b0);
        push_byte(dir, 1'b1);
    endtask

    function automatic t_byte wheel_level(input longint speed_mag, input longint peak);
        if (peak == 0) begin
            return LVL_ZERO;
        end
        return t_byte'((speed_mag * SPEED_LEVELS) / peak);
    endfunction

    // Wheel speeds are exact Q12.20 products; the levels scale each magnitude against
    // the largest of all three wheels.
    task automatic predict_motor_frame(input t_cmd fwd, lat, turn);
        longint turn_term, lat_term, fwd_term;
        longint wheel_a, wheel_b, wheel_c;
        longint mag_a, mag_b, mag_c, peak;
        t_byte  dir;
        turn_term = longint'(turn) * longint'(gain_turn);
        lat_term  = longint'(lat) * longint'(gain_lateral);
        fwd_term  = longint'(fwd) * longint'(gain_forward);
        wheel_a = turn_term - 2 * lat_term;
        wheel_b = turn_term + lat_term - fwd_term;
        wheel_c = turn_term + lat_term + fwd_term;
        mag_a = (wheel_a < 0) ? -wheel_a : wheel_a;
        mag_b = (wheel_b < 0) ? -wheel_b : wheel_b;
        mag_c = (wheel_c < 0) ? -wheel_c : wheel_c;
        peak = mag_a;
        if (mag_b > peak) peak = mag_b;
        if (mag_c > peak) peak = mag_c;
        dir = DIR_NONE;
        if (wheel_a < 0) dir |= DIR_A;
        if (wheel_b < 0) dir |= DIR_B;
        if (wheel_c < 0) dir |= DIR_C;
        push_frame(wheel_level(mag_a, peak), wheel_level(mag_b, peak),
                   wheel_level(mag_c, peak), dir);
    endtask

    // Offer one command, idling first at random unless the sender is in its steady phase.
    task automatic send_command(input t_cmd fwd, lat, turn);
        while (!sender_steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {turn, lat, fwd};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Leaves valid high so that back-to-back writes never lower and raise it in one step.
    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input t_gain value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TURN_GAIN:    gain_turn    = value;
            CFG_LATERAL_GAIN: gain_lateral = value;
            CFG_FORWARD_GAIN: gain_forward = value;
            default: ;  // The unused slot drops the write.
        endcase
    endtask

    // Program all three gains; a stray write to the unused slot goes first when asked.
    task automatic set_gains(input t_gain turn_g, lateral_g, forward_g, input bit stray);
        if (stray) begin
            write_gain(CFG_UNUSED_IDX, t_gain'($urandom));
        end
        write_gain(CFG_TURN_GAIN, turn_g);
        write_gain(CFG_LATERAL_GAIN, lateral_g);
        write_gain(CFG_FORWARD_GAIN, forward_g);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait until every predicted byte has been received.
    task automatic wait_frames_out();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes_q.size() != 0) @(posedge i_clk);
    endtask

    // Mostly wide random values, with extremes, zeros and small values near the sign change.
    function automatic t_cmd random_cmd();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return CMD_MAX;
                    1: return CMD_MIN;
                    2: return CMD_NEG1;
                    default: return CMD_ONE;
                endcase
            end
            1: return CMD_ZERO;
            2, 3, 4: return t_cmd'(int'($urandom_range(0, 1023)) - 512);
            default: return t_cmd'($urandom);
        endcase
    endfunction

    task automatic send_random_commands(input int count);
        t_cmd fwd, lat, turn;
        for (int n = 0; n < count; n++) begin
            fwd  = random_cmd();
            lat  = random_cmd();
            turn = random_cmd();
            send_command(fwd, lat, turn);
            predict_motor_frame(fwd, lat, turn);
        end
    endtask

    // Receiver: checks each accepted byte against the oldest prediction, then decides
    // tready for the next edge. One long hold-off lets the pipeline fill and stall its
    // input while the sender keeps offering; a later window of bytes runs with no stalls.
    always @(posedge i_clk) begin
        t_frame_byte want;
        static int hold_left = 0;
        static bit hold_done = 1'b0;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_bytes_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected frame byte %h last %b",
                                            m_axis_tdata, m_axis_tlast));
                end else begin
                    want = expected_bytes_q.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
                        note_mismatch($sformatf(
                            "frame byte %0d: expected %h last %b, got %h last %b",
                            bytes_seen, want.data, want.last, m_axis_tdata, m_axis_tlast));
                    end
                end
                bytes_seen++;
            end
            if (!hold_done && bytes_seen >= HOLD_AT_BYTE) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (bytes_seen >= STEADY_FROM && bytes_seen < STEADY_TO) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Stimulus: directed commands under the reset gains, then random commands across
    // several gain settings, each change made only once the framer has drained.
    initial begin
        t_cmd_row row;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            row = DIRECTED_ROWS[r];
            send_command(row.fwd, row.lat, row.turn);
            if (row.typed) begin
                push_frame(row.lvl_a, row.lvl_b, row.lvl_c, row.dir);
            end else begin
                predict_motor_frame(row.fwd, row.lat, row.turn);
            end
        end

        // Reset gains; a pause partway through lets the whole pipeline empty.
        send_random_commands(10);
        wait_frames_out();
        send_random_commands(25);
        wait_frames_out();

        // Largest gains give the widest products.
        set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b0);
        send_random_commands(20);
        wait_frames_out();

        // Zero gains: every wheel speed is zero, so every level and the direction are zero.
        set_gains(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 1'b1);
        send_random_commands(10);
        wait_frames_out();

        // No turn term: wheels depend only on lateral and forward.
        set_gains(GAIN_ZERO, t_gain'($urandom), t_gain'($urandom), 1'b0);
        send_random_commands(15);
        wait_frames_out();

        // Random gains with the sender offering back to back.
        set_gains(t_gain'($urandom), t_gain'($urandom), t_gain'($urandom), 1'b1);
        sender_steady = 1'b1;
        send_random_commands(20);
        sender_steady = 1'b0;
        wait_frames_out();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_bytes_q.size() == 0) begin
            $display("omni_wheel_speed_framer verification clean");
        end else begin
            $display("omni_wheel_speed_framer verification failed");
        end
        $finish;
    end

endmodule
